// ===== rtl/epoch_seconds_to_calendar_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the epoch seconds to calendar core
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define ES2CAL_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("es2cal: property failed");

// Next-cycle implication, masked while reset is high.
`define ES2CAL_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("es2cal: property failed");

// Next-cycle implication that also checks across reset.
`define ES2CAL_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("es2cal: reset property failed");

`endif

// ===== rtl/es2cal_pkg.sv =====
// ----------------------------------------------------------------------------
// es2cal_pkg
// Constants and tables for the epoch seconds to calendar pipeline.
// ----------------------------------------------------------------------------
package es2cal_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // floor(n / 675) for n < 2^24 : (n * MUL_DAY) >> 34
  localparam logic [24:0] MUL_DAY   = 25'd25451659;
  localparam int          SH_DAY    = 34;
  // floor(n / 225) for n < 5400 : (n * MUL_HOUR) >> 21
  localparam logic [13:0] MUL_HOUR  = 14'd9321;
  // floor(n / 15) for n < 900 : (n * MUL_MIN) >> 14
  localparam logic [10:0] MUL_MIN   = 11'd1093;
  // floor(n / 1461) for n < 2^15 : (n * MUL_QUAD) >> 26
  localparam logic [15:0] MUL_QUAD  = 16'd45934;

  localparam logic [16:0] SECS_DAY  = 17'd86400;
  localparam logic [11:0] SECS_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_MIN  = 6'd60;
  localparam logic [10:0] DAYS_QUAD = 11'd1461;
  localparam logic [8:0]  DAYS_YEAR = 9'd365;
  localparam logic [7:0]  CENTURY   = 8'd100;
  // 1969 is the first year of a four-year cycle ending in a leap year
  localparam logic [7:0]  BASE_Y00  = 8'd69;
  localparam logic [4:0]  CENT_19   = 5'd19;
  localparam logic [4:0]  CENT_20   = 5'd20;

  // Day of year on which month m (0 = January) starts.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Converts seconds since 1970-01-01 00:00:00 UTC into a UTC calendar date
// and time of day through a six-stage pipeline.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata fields, lowest bit first
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | epoch_seconds[30:0], pad[31]
//  m_axis   | out | year_century[4:0], year_in_century[11:5],
//           |     | month_number[15:12], day_of_month[20:16],
//           |     | hour_of_day[25:21], minute_of_hour[31:26],
//           |     | second_of_minute[37:32], pad[39:38]
//
// One transfer in per clock while m_axis is not stalled. Each input transfer
// loads stage 1, and the result is on m_axis once it reaches stage 6.
// The rate is set by the pipeline as a whole,
// which advances as one unit: it moves whenever the output register is empty
// or being taken. Reset clears only the stage valid bits. A stall on m_axis
// freezes every stage and drops s_axis_tready, so nothing is lost or repeated.
//
// Stages:
//   1  day count product (secs/128 times reciprocal of 675)
//   2  whole days, seconds into the day
//   3  hour product, four-year cycle product
//   4  hour, seconds into the hour, day within the four-year cycle
//   5  minute product, year within cycle, day of year, leap flag
//   6  minute, second, month, day of month, century split (output register)
//
// The four-year cycle shortcut is exact for 1970..2099, which covers the
// whole 31-bit input range (latest date January 2038).
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // epoch_seconds[30:0], pad [31] ignored
  input  logic [es2cal_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // year_century[4:0], year_in_century[11:5], month_number[15:12],
  // day_of_month[20:16], hour_of_day[25:21], minute_of_hour[31:26],
  // second_of_minute[37:32], zero pad [39:38]
  output logic [es2cal_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import es2cal_pkg::*;

  // Whole pipeline advances together.
  logic adv;
  logic [6:1] v;

  assign adv           = !v[6] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:1], s_axis_tvalid};
    end
  end

  // ---- stage 1: day reciprocal product ----
  logic [30:0] s1_secs;
  logic [48:0] s1_dprod;
  logic [30:0] in_secs;

  assign in_secs = s_axis_tdata[30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_secs  <= in_secs;
      s1_dprod <= 49'(in_secs[30:7]) * 49'(MUL_DAY);
    end
  end

  // ---- stage 2: days and seconds into the day ----
  logic [14:0] s1_days;
  logic [30:0] s1_dsecs;
  logic [14:0] s2_days;
  logic [16:0] s2_rem;

  assign s1_days  = s1_dprod[SH_DAY+14:SH_DAY];
  assign s1_dsecs = 31'(s1_days) * 31'(SECS_DAY);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_days <= s1_days;
      s2_rem  <= 17'(s1_secs - s1_dsecs);
    end
  end

  // ---- stage 3: hour product and four-year cycle product ----
  logic [16:0] s3_rem;
  logic [26:0] s3_hprod;
  logic [14:0] s3_dq;      // days since 1969-01-01
  logic [30:0] s3_qprod;
  logic [14:0] s2_dq;

  assign s2_dq = s2_days + 15'(DAYS_YEAR);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_rem   <= s2_rem;
      s3_hprod <= 27'(s2_rem[16:4]) * 27'(MUL_HOUR);
      s3_dq    <= s2_dq;
      s3_qprod <= 31'(s2_dq) * 31'(MUL_QUAD);
    end
  end

  // ---- stage 4: hour, seconds into hour, day within cycle ----
  logic [4:0]  s3_hour;
  logic [4:0]  s3_quad;
  logic [4:0]  s4_hour;
  logic [11:0] s4_r2;
  logic [4:0]  s4_quad;
  logic [10:0] s4_rq;

  assign s3_hour = s3_hprod[25:21];
  assign s3_quad = s3_qprod[30:26];

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_hour <= s3_hour;
      s4_r2   <= 12'(s3_rem - (17'(s3_hour) * 17'(SECS_HOUR)));
      s4_quad <= s3_quad;
      s4_rq   <= 11'(s3_dq - (15'(s3_quad) * 15'(DAYS_QUAD)));
    end
  end

  // ---- stage 5: minute product, year in cycle, day of year ----
  logic [1:0]  s4_yr;
  logic [8:0]  s4_doy;
  logic [4:0]  s5_hour;
  logic [11:0] s5_r2;
  logic [20:0] s5_mprod;
  logic [7:0]  s5_y00;     // years since 1900
  logic [8:0]  s5_doy;
  logic        s5_leap;

  always_comb begin
    if (s4_rq >= 11'(3 * DAYS_YEAR)) begin
      s4_yr  = 2'd3;
      s4_doy = 9'(s4_rq - 11'(3 * DAYS_YEAR));
    end else if (s4_rq >= 11'(2 * DAYS_YEAR)) begin
      s4_yr  = 2'd2;
      s4_doy = 9'(s4_rq - 11'(2 * DAYS_YEAR));
    end else if (s4_rq >= 11'(DAYS_YEAR)) begin
      s4_yr  = 2'd1;
      s4_doy = 9'(s4_rq - 11'(DAYS_YEAR));
    end else begin
      s4_yr  = 2'd0;
      s4_doy = s4_rq[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_hour  <= s4_hour;
      s5_r2    <= s4_r2;
      s5_mprod <= 21'(s4_r2[11:2]) * 21'(MUL_MIN);
      s5_y00   <= BASE_Y00 + {1'b0, s4_quad, 2'b00} + 8'(s4_yr);
      s5_doy   <= s4_doy;
      s5_leap  <= (s4_yr == 2'd3);
    end
  end

  // ---- stage 6: minute, second, month, day, century split ----
  logic [5:0] s5_min;
  logic [3:0] s5_mi;
  logic [4:0] s5_mday;
  logic       s5_c20;

  logic [4:0] o_cent;
  logic [6:0] o_yic;
  logic [3:0] o_month;
  logic [4:0] o_day;
  logic [4:0] o_hour;
  logic [5:0] o_min;
  logic [5:0] o_sec;

  assign s5_min = s5_mprod[19:14];
  assign s5_c20 = (s5_y00 >= CENTURY);

  // month starts rise monotonically, so the last start reached wins
  always_comb begin
    s5_mi = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s5_doy >= month_start(s5_leap, 4'(m))) begin
        s5_mi = 4'(m);
      end
    end
    s5_mday = 5'(s5_doy - month_start(s5_leap, s5_mi) + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_cent  <= s5_c20 ? CENT_20 : CENT_19;
      o_yic   <= s5_c20 ? 7'(s5_y00 - CENTURY) : s5_y00[6:0];
      o_month <= s5_mi + 4'd1;
      o_day   <= s5_mday;
      o_hour  <= s5_hour;
      o_min   <= s5_min;
      o_sec   <= 6'(s5_r2 - (12'(s5_min) * 12'(SECS_MIN)));
    end
  end

  assign m_axis_tvalid = v[6];
  assign m_axis_tdata  = {2'b00, o_sec, o_min, o_hour, o_day, o_month, o_yic, o_cent};

endmodule

// ===== rtl/es2cal_checker.sv =====
// ----------------------------------------------------------------------------
// es2cal_checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_core_assert.svh"

module es2cal_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [es2cal_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import es2cal_pkg::*;

  logic date_ok;
  logic tod_ok;

  assign date_ok = (m_axis_tdata[15:12] >= 4'd1) && (m_axis_tdata[15:12] <= 4'd12) &&
                   (m_axis_tdata[20:16] >= 5'd1) && (m_axis_tdata[11:5] <= 7'd99) &&
                   ((m_axis_tdata[4:0] == CENT_19) || (m_axis_tdata[4:0] == CENT_20));

  assign tod_ok = (m_axis_tdata[25:21] <= 5'd23) && (m_axis_tdata[31:26] <= 6'd59) &&
                  (m_axis_tdata[37:32] <= 6'd59) && (m_axis_tdata[39:38] == 2'b00);

  // a held result stays valid on the bus
  `ES2CAL_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // date fields stay within the calendar
  `ES2CAL_ASSERT_IMP(a_date, m_axis_tvalid, date_ok)

  // time of day fields stay within the day
  `ES2CAL_ASSERT_IMP(a_tod, m_axis_tvalid, tod_ok)

  // reset empties the pipeline
  `ES2CAL_ASSERT_RST(a_rst, rst, !m_axis_tvalid)

endmodule

bind epoch_seconds_to_calendar_core es2cal_checker u_es2cal_checker (.*);

// ===== test/epoch_seconds_to_calendar_core_test.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core_test
// Drives second counts into the calendar core over its input stream and
// checks every calendar result against a local year- and month-walking predictor. It
// covers fixed edge dates, month and year boundaries, uniform random times,
// the ignored top input bit, a long output stall and random gaps on both
// sides of the block.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core_test;

  import es2cal_pkg::*;

  localparam int unsigned SECS_MAX   = 32'h7FFF_FFFF;
  localparam int unsigned DAY_SECS   = 86400;
  localparam int unsigned LAST_DAY   = SECS_MAX / DAY_SECS;
  localparam int unsigned LONG_HOLD  = 200;
  localparam int unsigned TAIL_WAIT  = 20;
  localparam int unsigned RUN_LIMIT  = 12 * 400000;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                              31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [4:0] century;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } calendar_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // epoch_seconds[30:0], pad[31]
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // year_century[4:0], year_in_century[11:5], month_number[15:12],
  // day_of_month[20:16], hour_of_day[25:21], minute_of_hour[31:26],
  // second_of_minute[37:32], pad[39:38]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  calendar_t   pending_dates [$];
  calendar_t   want_date;
  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned dates_checked = 0;
  bit          idle_on       = 1'b1;
  bit          hold_request  = 1'b0;
  int unsigned sink_stall;

  epoch_seconds_to_calendar_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(input bit leap, input int unsigned m0);
    return MONTH_DAYS[m0] + ((leap && m0 == 1) ? 1 : 0);
  endfunction

  // Calendar date of a second count: strip the time of day, then walk whole
  // years from 1970 and whole months of the final year.
  function automatic calendar_t predict_date(input logic [30:0] secs);
    int unsigned days, rem, yr, mon, ylen;
    bit          lp;
    calendar_t   c;
    days     = secs / DAY_SECS;
    rem      = secs % DAY_SECS;
    c.hour   = 5'(rem / 3600);
    rem      = rem % 3600;
    c.minute = 6'(rem / 60);
    c.second = 6'(rem % 60);
    yr = 1970;
    forever begin
      lp   = leap_year(yr);
      ylen = lp ? 366 : 365;
      if (days < ylen) break;
      days -= ylen;
      yr++;
    end
    mon = 0;
    while (mon < 11 && days >= month_length(lp, mon)) begin
      days -= month_length(lp, mon);
      mon++;
    end
    c.century = 5'(yr / 100);
    c.year    = 7'(yr % 100);
    c.month   = 4'(mon + 1);
    c.day     = 5'(days + 1);
    return c;
  endfunction

  // Second count of a calendar date and time (month and day from 1).
  function automatic int unsigned secs_at(input int unsigned y, mo, d, h, mi, s);
    int unsigned days;
    days = d - 1;
    for (int unsigned yy = 1970; yy < y; yy++) days += leap_year(yy) ? 366 : 365;
    for (int unsigned m0 = 0; m0 + 1 < mo; m0++) days += month_length(leap_year(y), m0);
    return days * DAY_SECS + h * 3600 + mi * 60 + s;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long gap.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic check_field(input string what, input int unsigned want, got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Output checking and expectation capture share one process so that a
  // result and a new input in the same cycle are handled in a fixed order.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_dates.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want_date = pending_dates.pop_front();
          dates_checked++;
          check_field("year_century",     want_date.century, m_axis_tdata[4:0]);
          check_field("year_in_century",  want_date.year,    m_axis_tdata[11:5]);
          check_field("month_number",     want_date.month,   m_axis_tdata[15:12]);
          check_field("day_of_month",     want_date.day,     m_axis_tdata[20:16]);
          check_field("hour_of_day",      want_date.hour,    m_axis_tdata[25:21]);
          check_field("minute_of_hour",   want_date.minute,  m_axis_tdata[31:26]);
          check_field("second_of_minute", want_date.second,  m_axis_tdata[37:32]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_dates.push_back(predict_date(s_axis_tdata[30:0]));
      end
    end
  end

  // Receiver: random stalls while idling is on, or one long counted hold-off
  // when a test asks for it.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (idle_on) begin
        sink_stall = pick_gap();
        if (sink_stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (sink_stall) @(negedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      repeat (idle_on ? $urandom_range(1, 12) : 1) @(negedge clk);
    end
  end

  // One input transfer; returns after the accepting edge.
  task automatic send_seconds(input logic [30:0] secs, input logic top_bit = 1'b0);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {top_bit, secs};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic send_with_gap(input logic [30:0] secs, input logic top_bit = 1'b0);
    send_seconds(secs, top_bit);
    pause_sender(idle_on ? pick_gap() : 0);
  endtask

  task automatic wait_all_results();
    pause_sender(1);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    int unsigned stamps [$];
    stamps = '{0, 59, 3599, DAY_SECS - 1, DAY_SECS,
               secs_at(1970, 12, 31, 23, 59, 59), secs_at(1971, 1, 1, 0, 0, 0),
               secs_at(1972, 2, 28, 23, 59, 59), secs_at(1972, 2, 29, 0, 0, 0),
               secs_at(1972, 2, 29, 23, 59, 59), secs_at(1972, 3, 1, 0, 0, 0),
               secs_at(1973, 2, 28, 23, 59, 59), secs_at(1973, 3, 1, 0, 0, 0),
               secs_at(1999, 12, 31, 23, 59, 59), secs_at(2000, 1, 1, 0, 0, 0),
               secs_at(2000, 2, 29, 12, 34, 56), secs_at(2000, 12, 31, 23, 59, 59),
               secs_at(2001, 1, 1, 0, 0, 0), secs_at(2037, 12, 31, 23, 59, 59),
               secs_at(2038, 1, 1, 0, 0, 0), SECS_MAX, 32'h4000_0000,
               32'h5555_5555, 32'h2AAA_AAAA};
    foreach (stamps[i]) send_with_gap(stamps[i][30:0]);
  endtask

  // The pad bit above the 31-bit count must not change the date.
  task automatic test_ignored_top_bit();
    send_with_gap(31'd0, 1'b1);
    send_with_gap(SECS_MAX[30:0], 1'b1);
    send_with_gap(31'(secs_at(2000, 2, 29, 23, 59, 59)), 1'b1);
    send_with_gap(31'($urandom()), 1'b1);
  endtask

  // Last second of a month against first second of the next, plus random
  // pairs of adjacent seconds anywhere in range, some across midnight.
  task automatic test_calendar_edges(input int unsigned pairs);
    int unsigned y, mo, base;
    longint      secs;
    repeat (pairs) begin
      if ($urandom_range(0, 1)) begin
        y  = $urandom_range(1970, 2037);
        mo = $urandom_range(1, 12);
        base = secs_at(y, mo, month_length(leap_year(y), mo - 1), 23, 59, 59);
        send_with_gap(base[30:0]);
        send_with_gap(31'(base + 1));
      end else begin
        secs = longint'($urandom_range(0, LAST_DAY)) * DAY_SECS;
        case ($urandom_range(0, 2))
          0:       secs = secs + DAY_SECS - 1;
          1:       secs = secs + $urandom_range(0, DAY_SECS - 1);
          default: secs = secs;
        endcase
        if (secs > SECS_MAX) secs = SECS_MAX - $urandom_range(0, 11647);
        send_with_gap(31'(secs));
        send_with_gap(31'(secs + 1 > SECS_MAX ? SECS_MAX : secs + 1));
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering items back to back.
  task automatic test_backpressure(input int unsigned count);
    hold_request = 1'b1;
    repeat (count) send_seconds(31'($urandom()));
  endtask

  // Uniform counts; the first part runs with no idling on either side.
  task automatic test_uniform(input int unsigned count);
    idle_on = 1'b0;
    repeat (count / 4) send_with_gap(31'($urandom()));
    idle_on = 1'b1;
    repeat (count - count / 4) send_with_gap(31'($urandom()));
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    wait_all_results();
    test_ignored_top_bit();
    test_calendar_edges(150);
    test_backpressure(100);
    test_uniform(700);

    wait_all_results();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Covered %0d conversions: edge dates, month and year ends, top bit, stall, uniform.",
             items_sent);
    $display("%0d results compared, %0d mismatches.", dates_checked, errors);
    if (errors == 0 && pending_dates.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d results outstanding.", pending_dates.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
